### rtl/wml_pkg.sv
// shared types and constants for the windowed median rate lock
// no dependencies; imported by wml_ctrl, wml_dp and the top level
package wml_pkg;

  localparam int MAX_WINDOW_DEF = 16;
  localparam int SAMPLE_W       = 32;
  localparam int CNT_W          = 5;
  localparam int CFG_IDX_W      = 1;
  localparam int MIN_STATS      = 3;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_WINDOW_SIZE = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_STAB_THR    = 1'd1;

  localparam logic [CNT_W-1:0]    WIN_RST = 5'd16;
  localparam logic [SAMPLE_W-1:0] THR_RST = 32'd65536;

  // commands from the controller to the datapath
  typedef struct packed {
    logic take;      // capture the input sample
    logic write;     // write sample into the ring, advance pointer and fill
    logic clr_row;   // zero the sort row
    logic clr_idx;   // zero the step counter
    logic load;      // read one ring entry into the sort row
    logic sort;      // one odd-even transposition pass
    logic scan;      // shift the sorted row and pick out min, median, max
    logic decide;    // lock decision
    logic load_out;  // load the result register
  } wml_cmd_t;

  // status from the datapath to the controller
  typedef struct packed {
    logic in_nz;     // input sample is nonzero
    logic stats_ok;  // fill at least three
    logic idx_last;  // counter at fill - 1
    logic idx_full;  // counter at fill
  } wml_sts_t;

endpackage

### rtl/windowed_median_rate_lock_unit.sv
// windowed median rate lock, top level; one item in flight at a time
// out_valid rises after acceptance: for a zero sample straight from the done state,
//   with fewer than three in the window after the ring write and check, otherwise
//   after the ring read, n+1 sort passes, an n-step scan and the lock decision
// next item: in_stall drops in the cycle after the result is registered
// reset: synchronous active-low; clears pointers, fill, statistics and lock
module windowed_median_rate_lock_unit #(
  parameter int MAX_WINDOW = wml_pkg::MAX_WINDOW_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_we,
  input  logic [wml_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [wml_pkg::SAMPLE_W-1:0]  cfg_data,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [wml_pkg::SAMPLE_W-1:0]  in_sample,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic                          out_accepted,
  output logic [wml_pkg::SAMPLE_W-1:0]  out_locked_rate,
  output logic [wml_pkg::SAMPLE_W-1:0]  out_swing,
  output logic [wml_pkg::SAMPLE_W-1:0]  out_median_now,
  output logic                          out_is_stable,
  output logic [wml_pkg::CNT_W-1:0]     out_sample_count
);
  import wml_pkg::*;

  wml_cmd_t cmd;
  wml_sts_t sts;

  wml_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .sts       (sts),
    .cmd       (cmd)
  );

  wml_dp #(
    .MAX_WINDOW (MAX_WINDOW)
  ) u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_we           (cfg_we),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data),
    .in_sample        (in_sample),
    .cmd              (cmd),
    .sts              (sts),
    .out_accepted     (out_accepted),
    .out_locked_rate  (out_locked_rate),
    .out_swing        (out_swing),
    .out_median_now   (out_median_now),
    .out_is_stable    (out_is_stable),
    .out_sample_count (out_sample_count)
  );

endmodule

### rtl/wml_ctrl.sv
// controller state machine for the windowed median rate lock
// depends on wml_pkg; drives wml_dp through wml_cmd_t, reads wml_sts_t
module wml_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  output logic              out_valid,
  input  logic              out_stall,
  input  wml_pkg::wml_sts_t sts,
  output wml_pkg::wml_cmd_t cmd
);
  import wml_pkg::*;

  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_WRITE  = 4'd1;
  localparam logic [3:0] S_CHECK  = 4'd2;
  localparam logic [3:0] S_LOAD   = 4'd3;
  localparam logic [3:0] S_LWAIT  = 4'd4;
  localparam logic [3:0] S_SORT   = 4'd5;
  localparam logic [3:0] S_SCAN   = 4'd6;
  localparam logic [3:0] S_DECIDE = 4'd7;
  localparam logic [3:0] S_DONE   = 4'd8;

  logic [3:0] state_r, state_nxt;
  logic       out_valid_r, out_valid_nxt;
  logic       out_free;

  assign in_stall  = (state_r != S_IDLE);
  assign out_valid = out_valid_r;
  assign out_free  = !out_valid_r || !out_stall;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.take  = 1'b1;
          state_nxt = sts.in_nz ? S_WRITE : S_DONE;
        end
      end
      S_WRITE: begin
        cmd.write = 1'b1;
        state_nxt = S_CHECK;
      end
      S_CHECK: begin
        if (sts.stats_ok) begin
          cmd.clr_row = 1'b1;
          cmd.clr_idx = 1'b1;
          state_nxt   = S_LOAD;
        end else begin
          state_nxt = S_DONE;
        end
      end
      S_LOAD: begin
        cmd.load = 1'b1;
        if (sts.idx_last) begin
          cmd.clr_idx = 1'b1;
          state_nxt   = S_LWAIT;
        end
      end
      S_LWAIT: begin
        // last read word lands in the row this cycle
        state_nxt = S_SORT;
      end
      S_SORT: begin
        cmd.sort = 1'b1;
        if (sts.idx_full) begin
          cmd.clr_idx = 1'b1;
          state_nxt   = S_SCAN;
        end
      end
      S_SCAN: begin
        cmd.scan = 1'b1;
        if (sts.idx_last) begin
          state_nxt = S_DECIDE;
        end
      end
      S_DECIDE: begin
        cmd.decide = 1'b1;
        state_nxt  = S_DONE;
      end
      S_DONE: begin
        if (out_free) begin
          cmd.load_out = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.load_out) begin
      out_valid_nxt = 1'b1;
    end else if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

### rtl/wml_dp.sv
// datapath for the windowed median rate lock: config registers, sample ring,
// sort row with odd-even transposition passes, lock state and result register
// depends on wml_pkg; controlled by wml_ctrl
module wml_dp #(
  parameter int MAX_WINDOW = wml_pkg::MAX_WINDOW_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              cfg_we,
  input  logic [wml_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [wml_pkg::SAMPLE_W-1:0]      cfg_data,
  input  logic [wml_pkg::SAMPLE_W-1:0]      in_sample,
  input  wml_pkg::wml_cmd_t                 cmd,
  output wml_pkg::wml_sts_t                 sts,
  output logic                              out_accepted,
  output logic [wml_pkg::SAMPLE_W-1:0]      out_locked_rate,
  output logic [wml_pkg::SAMPLE_W-1:0]      out_swing,
  output logic [wml_pkg::SAMPLE_W-1:0]      out_median_now,
  output logic                              out_is_stable,
  output logic [wml_pkg::CNT_W-1:0]         out_sample_count
);
  import wml_pkg::*;

  localparam int FW = $clog2(MAX_WINDOW + 1);
  localparam int PW = $clog2(MAX_WINDOW);

  typedef logic [SAMPLE_W-1:0] word_t;

  // configuration
  logic [CNT_W-1:0] win_r;
  word_t            thr_r;

  // architectural state
  logic [PW-1:0] wp_r;
  logic [FW-1:0] fill_r;
  word_t         low_r, high_r, mid_r;
  logic          stable_r;
  word_t         held_rate_r, held_spread_r;

  // working registers
  word_t         s_r;
  logic [FW-1:0] idx_r;
  logic          ld_v_r;
  word_t         rd_data_r;
  word_t         row_r [MAX_WINDOW];
  word_t         row_nxt [MAX_WINDOW];
  word_t         ring [MAX_WINDOW];

  logic [FW-1:0] w_eff;
  logic [FW-1:0] wp_base, wp_inc, fill_clamp, fill_new, mid_j;
  logic [PW-1:0] wp_next;
  word_t         top, spread;
  logic          lock;

  // effective window, clamped to one through MAX_WINDOW
  always_comb begin
    if (win_r == '0) begin
      w_eff = FW'(1);
    end else if (32'(win_r) > 32'(MAX_WINDOW)) begin
      w_eff = FW'(MAX_WINDOW);
    end else begin
      w_eff = FW'(win_r);
    end
  end

  // pointer and fill update for a nonzero sample
  assign wp_base    = (FW'(wp_r) >= w_eff) ? '0 : FW'(wp_r);
  assign wp_inc     = wp_base + FW'(1);
  assign wp_next    = (wp_inc == w_eff) ? '0 : PW'(wp_inc);
  assign fill_clamp = (fill_r > w_eff) ? w_eff : fill_r;
  assign fill_new   = (fill_clamp < w_eff) ? fill_clamp + FW'(1) : fill_clamp;

  // sorted index n/2 reaches the top tap after n-1-n/2 upward shifts
  assign mid_j  = fill_r - FW'(1) - (fill_r >> 1);
  assign top    = row_r[MAX_WINDOW-1];
  assign spread = high_r - low_r;
  assign lock   = (fill_r >= w_eff) && (spread < thr_r) &&
                  (!stable_r || (spread < held_spread_r));

  assign sts.in_nz    = (in_sample != '0);
  assign sts.stats_ok = (fill_r >= FW'(MIN_STATS));
  assign sts.idx_last = (idx_r == fill_r - FW'(1));
  assign sts.idx_full = (idx_r == fill_r);

  // next row: load shift, transposition pass or upward scan shift
  always_comb begin
    for (int i = 0; i < MAX_WINDOW; i++) begin
      row_nxt[i] = row_r[i];
    end
    if (cmd.clr_row) begin
      for (int i = 0; i < MAX_WINDOW; i++) begin
        row_nxt[i] = '0;
      end
    end else if (ld_v_r) begin
      for (int i = 0; i < MAX_WINDOW - 1; i++) begin
        row_nxt[i] = row_r[i+1];
      end
      row_nxt[MAX_WINDOW-1] = rd_data_r;
    end else if (cmd.sort) begin
      // pairs start at even or odd positions on alternate passes
      for (int i = 0; i < MAX_WINDOW - 1; i++) begin
        if ((1'(i) == idx_r[0]) && (row_r[i] > row_r[i+1])) begin
          row_nxt[i]   = row_r[i+1];
          row_nxt[i+1] = row_r[i];
        end
      end
    end else if (cmd.scan) begin
      for (int i = 1; i < MAX_WINDOW; i++) begin
        row_nxt[i] = row_r[i-1];
      end
      row_nxt[0] = '0;
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < MAX_WINDOW; i++) begin
      row_r[i] <= row_nxt[i];
    end
  end

  // sample ring
  always_ff @(posedge clk) begin
    if (cmd.write) begin
      ring[PW'(wp_base)] <= s_r;
    end
    if (cmd.load) begin
      rd_data_r <= ring[idx_r[PW-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.take) begin
      s_r <= in_sample;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      win_r         <= WIN_RST;
      thr_r         <= THR_RST;
      wp_r          <= '0;
      fill_r        <= '0;
      low_r         <= '0;
      high_r        <= '0;
      mid_r         <= '0;
      stable_r      <= 1'b0;
      held_rate_r   <= '0;
      held_spread_r <= '0;
      idx_r         <= '0;
      ld_v_r        <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_WINDOW_SIZE: win_r <= cfg_data[CNT_W-1:0];
          CFG_STAB_THR:    thr_r <= cfg_data;
          default:         ;
        endcase
      end
      ld_v_r <= cmd.load;
      if (cmd.clr_idx) begin
        idx_r <= '0;
      end else if (cmd.load || cmd.sort || cmd.scan) begin
        idx_r <= idx_r + FW'(1);
      end
      if (cmd.write) begin
        wp_r   <= wp_next;
        fill_r <= fill_new;
      end
      if (cmd.scan) begin
        if (idx_r == '0) begin
          high_r <= top;
        end
        if (idx_r == mid_j) begin
          mid_r <= top;
        end
        if (sts.idx_last) begin
          low_r <= top;
        end
      end
      if (cmd.decide && lock) begin
        stable_r      <= 1'b1;
        held_rate_r   <= mid_r;
        held_spread_r <= spread;
      end
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      out_accepted     <= (s_r != '0);
      out_locked_rate  <= (stable_r && sts.stats_ok) ? held_rate_r : '0;
      out_swing        <= sts.stats_ok ? spread : '0;
      out_median_now   <= mid_r;
      out_is_stable    <= stable_r;
      out_sample_count <= CNT_W'(fill_r);
    end
  end

endmodule

### tb/windowed_median_rate_lock_unit_tb.sv
// self-checking testbench for windowed_median_rate_lock_unit: directed table, then random items
// under three idle/stall mixes, each checked against typed values or a rate-lock predictor
// depends on wml_pkg and the top-level rtl only
module windowed_median_rate_lock_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import wml_pkg::*;

  localparam int DEPTH        = MAX_WINDOW_DEF;
  localparam int QUIET_LIMIT  = 4000;
  localparam int DRAIN_CYCLES = 3 * DEPTH + 20;
  localparam int MAX_REPORTS  = 10;
  localparam int PHASE_ITEMS  = 365;

  typedef logic [SAMPLE_W-1:0] rate_t;

  typedef struct packed {
    logic             accepted;
    rate_t            locked_rate;
    rate_t            swing;
    rate_t            median_now;
    logic             is_stable;
    logic [CNT_W-1:0] sample_count;
  } rate_result_t;

  typedef enum logic {ROW_ITEM, ROW_REG} row_kind_t;

  typedef struct {
    row_kind_t            kind;
    logic [CFG_IDX_W-1:0] idx;
    rate_t                data;
    bit                   typed;
    rate_result_t         want;
  } stim_row_t;

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = CFG_WINDOW_SIZE;
  rate_t                cfg_data = '0;
  logic                 in_valid = 1'b0;
  logic                 in_stall;
  rate_t                in_sample = '0;
  logic                 out_valid;
  logic                 out_stall = 1'b0;
  logic                 out_accepted;
  rate_t                out_locked_rate;
  rate_t                out_swing;
  rate_t                out_median_now;
  logic                 out_is_stable;
  logic [CNT_W-1:0]     out_sample_count;

  int send_idle_pct  = 0;
  int recv_stall_pct = 0;
  int fail_count     = 0;
  int quiet_cycles   = 0;

  rate_result_t pending_results [$];

  // predictor state
  rate_t            ring_m [DEPTH];
  logic [DEPTH-1:0] ring_written;
  logic [3:0]       wr_ptr;
  logic [CNT_W-1:0] fill_m;
  rate_t            low_m, high_m, mid_m, held_rate_m, held_spread_m;
  logic             stable_m;
  logic [CNT_W-1:0] win_reg;
  rate_t            thr_reg;

  windowed_median_rate_lock_unit i_dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_we           (cfg_we),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_sample        (in_sample),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_accepted     (out_accepted),
    .out_locked_rate  (out_locked_rate),
    .out_swing        (out_swing),
    .out_median_now   (out_median_now),
    .out_is_stable    (out_is_stable),
    .out_sample_count (out_sample_count)
  );

  always #5 clk = ~clk;

  function automatic int eff_window(logic [CNT_W-1:0] w);
    if (w == 0) return 1;
    if (w > DEPTH) return DEPTH;
    return int'(w);
  endfunction

  // a new window must never make the block read a ring entry that was never written
  function automatic bit window_is_safe(int w);
    if (w <= fill_m || wr_ptr == fill_m) return 1'b1;
    for (int i = 0; i < w; i++) begin
      if (!ring_written[i]) return 1'b0;
    end
    return 1'b1;
  endfunction

  function automatic rate_result_t predict_rate_lock(rate_t s);
    rate_t        sorted [DEPTH];
    rate_t        key;
    rate_t        spread;
    int           w;
    int           n;
    int           j;
    rate_result_t r;
    if (s != 0) begin
      w = eff_window(win_reg);
      if (wr_ptr >= w) wr_ptr = '0;
      if (fill_m > w) fill_m = CNT_W'(w);
      ring_m[wr_ptr] = s;
      ring_written[wr_ptr] = 1'b1;
      wr_ptr = 4'((int'(wr_ptr) + 1) % w);
      if (fill_m < w) fill_m++;
      n = int'(fill_m);
      if (n >= MIN_STATS) begin
        for (int i = 0; i < n; i++) sorted[i] = ring_m[i];
        for (int i = 1; i < n; i++) begin
          key = sorted[i];
          j = i;
          while (j > 0 && sorted[j-1] > key) begin
            sorted[j] = sorted[j-1];
            j--;
          end
          sorted[j] = key;
        end
        low_m  = sorted[0];
        high_m = sorted[n-1];
        mid_m  = sorted[n/2];
        spread = high_m - low_m;
        // lock on a full quiet window, relock only on a tighter spread
        if (n >= w && spread < thr_reg && (!stable_m || spread < held_spread_m)) begin
          stable_m      = 1'b1;
          held_rate_m   = mid_m;
          held_spread_m = spread;
        end
      end
    end
    r.accepted     = (s != 0);
    r.locked_rate  = (stable_m && fill_m >= MIN_STATS) ? held_rate_m : '0;
    r.swing        = (fill_m >= MIN_STATS) ? high_m - low_m : '0;
    r.median_now   = mid_m;
    r.is_stable    = stable_m;
    r.sample_count = fill_m;
    return r;
  endfunction

  task automatic report(string msg);
    fail_count++;
    if (fail_count <= MAX_REPORTS) $display("%s", msg);
  endtask

  task automatic send_item(rate_t s, bit typed, rate_result_t want);
    rate_result_t predicted;
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid  <= 1'b1;
    in_sample <= s;
    do @(posedge clk); while (in_stall);
    predicted = predict_rate_lock(s);
    pending_results.push_back(typed ? want : predicted);
  endtask

  // hold the sender until every expected result is back, end on a rising edge
  task automatic drain_results();
    in_valid <= 1'b0;
    @(negedge clk);
    while (pending_results.size() != 0) @(negedge clk);
    @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, rate_t v);
    drain_results();
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == CFG_WINDOW_SIZE) win_reg = v[CNT_W-1:0];
    else thr_reg = v;
  endtask

  task automatic run_random(int idle_pct, int stall_pct, int target);
    int               taken;
    int               seg_len;
    int               roll;
    rate_t            base;
    rate_t            jitter;
    rate_t            s;
    rate_t            v;
    logic [CNT_W-1:0] raw;
    send_idle_pct  = idle_pct;
    recv_stall_pct = stall_pct;
    taken = 0;
    while (taken < target) begin
      case ($urandom_range(0, 4))
        0: jitter = 32'h0;
        1: jitter = 32'h3;
        2: jitter = 32'hFF;
        3: jitter = 32'hFFFF;
        default: jitter = 32'h4_0000;
      endcase
      base = $urandom >> $urandom_range(0, 20);
      if ($urandom_range(0, 1) == 1) begin
        do begin
          case ($urandom_range(0, 9))
            0: raw = 5'd0;
            1: raw = CNT_W'($urandom_range(17, 31));
            2: raw = 5'd16;
            3: raw = CNT_W'($urandom_range(9, 15));
            default: raw = CNT_W'($urandom_range(1, 8));
          endcase
        end while (!window_is_safe(eff_window(raw)));
        v = $urandom;
        v[CNT_W-1:0] = raw;
        write_reg(CFG_WINDOW_SIZE, v);
      end
      if ($urandom_range(0, 9) < 6) begin
        case ($urandom_range(0, 9))
          0: v = '0;
          1: v = '1;
          2: v = $urandom;
          default: v = $urandom_range(0, 2 * jitter + 2);
        endcase
        write_reg(CFG_STAB_THR, v);
      end
      seg_len = $urandom_range(4, 40);
      repeat (seg_len) begin
        roll = $urandom_range(0, 99);
        // mostly clustered rates so windows fill and lock, some noise and dropouts
        if (roll < 5) s = '0;
        else if (roll < 15) s = $urandom;
        else s = base + $urandom_range(0, jitter);
        send_item(s, 1'b0, '0);
        taken++;
      end
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) out_stall <= 1'b0;
    else out_stall <= ($urandom_range(0, 99) < recv_stall_pct);
  end

  always @(posedge clk) begin : result_check
    rate_result_t got;
    rate_result_t want;
    if (rst_n && out_valid && !out_stall) begin
      got = '{out_accepted, out_locked_rate, out_swing, out_median_now, out_is_stable,
              out_sample_count};
      if (pending_results.size() == 0) begin
        report($sformatf(
          "unexpected result at %0t: acc=%0b lock=%h swing=%h med=%h stable=%0b cnt=%0d",
          $realtime, got.accepted, got.locked_rate, got.swing, got.median_now,
          got.is_stable, got.sample_count));
      end else begin
        want = pending_results.pop_front();
        if (got !== want) begin
          report($sformatf(
            "mismatch at %0t: exp acc=%0b lock=%h swing=%h med=%h stable=%0b cnt=%0d",
            $realtime, want.accepted, want.locked_rate, want.swing,
            want.median_now, want.is_stable, want.sample_count));
          if (fail_count <= MAX_REPORTS) begin
            $display("                   got acc=%0b lock=%h swing=%h med=%h stable=%0b cnt=%0d",
                     got.accepted, got.locked_rate, got.swing, got.median_now, got.is_stable,
                     got.sample_count);
          end
        end
      end
    end
  end

  // watchdog: too long without any item moving on either side
  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles == QUIET_LIMIT) begin
        $display("TB_ERROR");
        $finish;
      end
    end
  end

  initial begin
    stim_row_t stim_table [$];
    win_reg       = WIN_RST;
    thr_reg       = THR_RST;
    ring_written  = '0;
    wr_ptr        = '0;
    fill_m        = '0;
    low_m         = '0;
    high_m        = '0;
    mid_m         = '0;
    stable_m      = 1'b0;
    held_rate_m   = '0;
    held_spread_m = '0;
    for (int i = 0; i < DEPTH; i++) ring_m[i] = '0;

    // after reset: zero sample ignored, then the window fills from the extremes
    stim_table.push_back('{ROW_ITEM, CFG_WINDOW_SIZE, 32'h0, 1'b1,
                           rate_result_t'{1'b0, 32'h0, 32'h0, 32'h0, 1'b0, 5'd0}});
    stim_table.push_back('{ROW_ITEM, CFG_WINDOW_SIZE, 32'hFFFF_FFFF, 1'b1,
                           rate_result_t'{1'b1, 32'h0, 32'h0, 32'h0, 1'b0, 5'd1}});
    stim_table.push_back('{ROW_ITEM, CFG_WINDOW_SIZE, 32'h1, 1'b1,
                           rate_result_t'{1'b1, 32'h0, 32'h0, 32'h0, 1'b0, 5'd2}});
    stim_table.push_back('{ROW_ITEM, CFG_WINDOW_SIZE, 32'h8000_0000, 1'b1,
                           rate_result_t'{1'b1, 32'h0, 32'hFFFF_FFFE, 32'h8000_0000, 1'b0, 5'd3}});
    stim_table.push_back('{ROW_REG, CFG_STAB_THR, 32'hFFFF_FFFF, 1'b0, '0});
    // window field 31 acts as the full depth
    stim_table.push_back('{ROW_REG, CFG_WINDOW_SIZE, 32'hFFFF_FFFF, 1'b0, '0});
    stim_table.push_back('{ROW_ITEM, CFG_WINDOW_SIZE, 32'h0001_8000, 1'b0, '0});
    // shrink while running: pointer wraps, window full, first lock
    stim_table.push_back('{ROW_REG, CFG_WINDOW_SIZE, 32'd4, 1'b0, '0});
    stim_table.push_back('{ROW_ITEM, CFG_WINDOW_SIZE, 32'h0001_0000, 1'b0, '0});
    stim_table.push_back('{ROW_ITEM, CFG_WINDOW_SIZE, 32'h0001_0000, 1'b0, '0});
    stim_table.push_back('{ROW_ITEM, CFG_WINDOW_SIZE, 32'h0001_0000, 1'b0, '0});
    stim_table.push_back('{ROW_ITEM, CFG_WINDOW_SIZE, 32'h0001_0000, 1'b0, '0});
    stim_table.push_back('{ROW_REG, CFG_STAB_THR, 32'h0, 1'b0, '0});
    stim_table.push_back('{ROW_ITEM, CFG_WINDOW_SIZE, 32'h0002_0000, 1'b0, '0});
    // window zero acts as one: fill drops below three while still locked
    stim_table.push_back('{ROW_REG, CFG_WINDOW_SIZE, 32'd0, 1'b0, '0});
    stim_table.push_back('{ROW_ITEM, CFG_WINDOW_SIZE, 32'hFFFF_FFFF, 1'b0, '0});
    stim_table.push_back('{ROW_ITEM, CFG_WINDOW_SIZE, 32'h0, 1'b0, '0});
    stim_table.push_back('{ROW_REG, CFG_WINDOW_SIZE, 32'd3, 1'b0, '0});
    stim_table.push_back('{ROW_ITEM, CFG_WINDOW_SIZE, 32'h0001_0000, 1'b0, '0});
    stim_table.push_back('{ROW_ITEM, CFG_WINDOW_SIZE, 32'h0001_0001, 1'b0, '0});
    stim_table.push_back('{ROW_ITEM, CFG_WINDOW_SIZE, 32'h0000_FFFF, 1'b0, '0});
    stim_table.push_back('{ROW_REG, CFG_STAB_THR, THR_RST, 1'b0, '0});
    stim_table.push_back('{ROW_ITEM, CFG_WINDOW_SIZE, 32'h0001_0002, 1'b0, '0});

    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    send_idle_pct  = 29;
    recv_stall_pct = 65;
    foreach (stim_table[k]) begin
      if (stim_table[k].kind == ROW_REG) write_reg(stim_table[k].idx, stim_table[k].data);
      else send_item(stim_table[k].data, stim_table[k].typed, stim_table[k].want);
    end

    run_random(29, 65, PHASE_ITEMS);
    run_random(65, 29, PHASE_ITEMS);
    run_random(0, 0, PHASE_ITEMS);

    drain_results();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0 && pending_results.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
